/* hw/rtl/akms_pkg.sv */
// Shared types, constants and the head ordering function for the merge selector.
package akms_pkg;

    localparam int KEY_W = 32;
    localparam int SID_W = 4;
    localparam int CFG_W = 5;

    localparam logic [1:0] MATE_BOTH   = 2'b11;
    localparam logic [1:0] MATE_SECOND = 2'b10;

    typedef struct packed {
        logic signed [KEY_W-1:0] ref_id;
        logic signed [KEY_W-1:0] start_pos;
        logic signed [KEY_W-1:0] end_pos;
        logic [1:0]              mate;
    } akms_rec_t;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic issue;
        logic emit;
    } akms_cmd_t;

    typedef struct packed {
        logic all_ok;
        logic scan_last;
        logic out_free;
    } akms_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_LAST  = 5'b01000,
        ST_EMIT  = 5'b10000
    } akms_state_t;

    // True when candidate c must replace the current best b (c comes later in the scan).
    function automatic logic beats(akms_rec_t c, akms_rec_t b);
        logic res;
        if (c.ref_id != b.ref_id) begin
            res = (c.ref_id < b.ref_id);
        end else if (c.start_pos != b.start_pos) begin
            res = (c.start_pos < b.start_pos);
        end else if (c.end_pos != b.end_pos) begin
            res = (c.end_pos < b.end_pos);
        end else if (((c.mate | b.mate) & MATE_BOTH) == MATE_BOTH) begin
            res = ((c.mate & MATE_SECOND) == 2'b00);
        end else begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/alignment_kway_merge_selector.sv */
// Top level of the k-way merge selector: controller, datapath and checks.
// Each transaction refills one stream's head or marks it ended; a write to a stream at or
// beyond the streams in use is dropped. While some stream in use still lacks a head and is not
// ended, the transaction ends with no result; otherwise a serial scan over the streams in use
// reads one head a cycle from the head memory into a single key comparator; the result waits
// on m_ready while the output register is held. The result then gives the smallest head, or a
// completion with all_done set once every stream in use is ended and empty. Heads need no
// clearing pass after reset. Write cfg_wdata only while no transaction is in flight.
module alignment_kway_merge_selector #(
    parameter int NUM_STREAMS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [akms_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [akms_pkg::SID_W-1:0]        s_stream_id,
    input  logic                              s_stream_ended,
    input  logic signed [akms_pkg::KEY_W-1:0] s_ref_id,
    input  logic signed [akms_pkg::KEY_W-1:0] s_start_pos,
    input  logic signed [akms_pkg::KEY_W-1:0] s_end_pos,
    input  logic                              s_is_first_mate,
    input  logic                              s_is_second_mate,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [akms_pkg::SID_W-1:0]        m_winner_stream,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_ref_id,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_start,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_end,
    output logic                              m_out_first_mate,
    output logic                              m_out_second_mate,
    output logic                              m_all_done
);
    import akms_pkg::*;

    akms_cmd_t cmd;
    akms_sts_t sts;

    akms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    akms_dp #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_stream_id       (s_stream_id),
        .s_stream_ended    (s_stream_ended),
        .s_ref_id          (s_ref_id),
        .s_start_pos       (s_start_pos),
        .s_end_pos         (s_end_pos),
        .s_is_first_mate   (s_is_first_mate),
        .s_is_second_mate  (s_is_second_mate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_winner_stream   (m_winner_stream),
        .m_out_ref_id      (m_out_ref_id),
        .m_out_start       (m_out_start),
        .m_out_end         (m_out_end),
        .m_out_first_mate  (m_out_first_mate),
        .m_out_second_mate (m_out_second_mate),
        .m_all_done        (m_all_done),
        .cmd               (cmd),
        .sts               (sts)
    );

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result issued while output register still held");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction taken before previous one finished");

    a_done_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_all_done) |-> (m_winner_stream == '0 && m_out_ref_id == '0
                                     && !m_out_first_mate && !m_out_second_mate))
        else $error("completion carries record data");

endmodule

/* hw/rtl/akms_ctrl.sv */
// Sequencing state machine: accept, readiness check, head scan, result hand-off.
module akms_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  akms_pkg::akms_sts_t sts,
    output akms_pkg::akms_cmd_t cmd
);
    import akms_pkg::*;

    akms_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.all_ok) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/akms_dp.sv */
// Datapath: stream flags, head memory, serial minimum search and output register.
module akms_dp #(
    parameter int NUM_STREAMS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [akms_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [akms_pkg::SID_W-1:0]     s_stream_id,
    input  logic                           s_stream_ended,
    input  logic signed [akms_pkg::KEY_W-1:0] s_ref_id,
    input  logic signed [akms_pkg::KEY_W-1:0] s_start_pos,
    input  logic signed [akms_pkg::KEY_W-1:0] s_end_pos,
    input  logic                           s_is_first_mate,
    input  logic                           s_is_second_mate,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [akms_pkg::SID_W-1:0]     m_winner_stream,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_ref_id,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_start,
    output logic signed [akms_pkg::KEY_W-1:0] m_out_end,
    output logic                           m_out_first_mate,
    output logic                           m_out_second_mate,
    output logic                           m_all_done,
    input  akms_pkg::akms_cmd_t             cmd,
    output akms_pkg::akms_sts_t             sts
);
    import akms_pkg::*;

    localparam int IDX_W = $clog2(NUM_STREAMS);
    localparam int CNT_W = $clog2(NUM_STREAMS + 1);

    logic [CFG_W-1:0]       cfg_reg;
    logic [CNT_W-1:0]       n_eff;
    logic [NUM_STREAMS-1:0] present_reg;
    logic [NUM_STREAMS-1:0] finished_reg;
    logic [NUM_STREAMS-1:0] slot_ok;
    akms_rec_t              mem [NUM_STREAMS];
    akms_rec_t              rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       scan_idx_reg;
    akms_rec_t              best_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   any_reg;
    logic                   m_valid_reg;
    logic                   wr_hit;
    logic [IDX_W-1:0]       wr_idx;
    akms_rec_t              wr_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(16);
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (cfg_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(cfg_reg) > NUM_STREAMS) begin
            n_eff = CNT_W'(NUM_STREAMS);
        end else begin
            n_eff = CNT_W'(cfg_reg);
        end
    end

    assign wr_hit = cmd.accept && (32'(s_stream_id) < 32'(n_eff));
    assign wr_idx = IDX_W'(s_stream_id);
    assign wr_rec = '{ref_id: s_ref_id, start_pos: s_start_pos, end_pos: s_end_pos,
                      mate: {s_is_second_mate, s_is_first_mate}};

    always_comb begin
        for (int i = 0; i < NUM_STREAMS; i++) begin
            slot_ok[i] = (i >= 32'(n_eff)) || present_reg[i] || finished_reg[i];
        end
    end

    assign sts.all_ok    = &slot_ok;
    assign sts.scan_last = (32'(scan_idx_reg) == 32'(n_eff) - 32'd1);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg  <= '0;
            finished_reg <= '0;
        end else begin
            if (wr_hit) begin
                if (s_stream_ended) begin
                    finished_reg[wr_idx] <= 1'b1;
                end else begin
                    present_reg[wr_idx] <= 1'b1;
                end
            end
            if (cmd.emit && any_reg) begin
                present_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hit && !s_stream_ended) begin
            mem[wr_idx] <= wr_rec;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            any_reg      <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.issue && present_reg[scan_idx_reg];
            rd_idx_reg   <= scan_idx_reg;
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
                any_reg      <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (rd_valid_reg && (!any_reg || beats(rd_data_reg, best_reg))) begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg && (!any_reg || beats(rd_data_reg, best_reg))) begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (any_reg) begin
                m_winner_stream   <= SID_W'(best_idx_reg);
                m_out_ref_id      <= best_reg.ref_id;
                m_out_start       <= best_reg.start_pos;
                m_out_end         <= best_reg.end_pos;
                m_out_first_mate  <= best_reg.mate[0];
                m_out_second_mate <= best_reg.mate[1];
                m_all_done        <= 1'b0;
            end else begin
                m_winner_stream   <= '0;
                m_out_ref_id      <= '0;
                m_out_start       <= '0;
                m_out_end         <= '0;
                m_out_first_mate  <= 1'b0;
                m_out_second_mate <= 1'b0;
                m_all_done        <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* dv/tb.sv */
// Testbench for the k-way merge selector: directed and random merge traffic checked against a predictor.
module tb;
    import akms_pkg::*;

    localparam int NUM_STREAMS   = 16;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_GAP       = 14;
    localparam int SESSION_STEPS = 600;

    localparam logic [KEY_W-1:0]        SIGN_FLIP = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_NONE  = -32'sd1;

    typedef struct {
        logic [SID_W-1:0]        winner;
        logic signed [KEY_W-1:0] ref_id;
        logic signed [KEY_W-1:0] start_pos;
        logic signed [KEY_W-1:0] end_pos;
        logic                    first_mate;
        logic                    second_mate;
        logic                    all_done;
    } merge_emit_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [SID_W-1:0]        s_stream_id;
    logic                    s_stream_ended;
    logic signed [KEY_W-1:0] s_ref_id;
    logic signed [KEY_W-1:0] s_start_pos;
    logic signed [KEY_W-1:0] s_end_pos;
    logic                    s_is_first_mate;
    logic                    s_is_second_mate;
    logic                    m_valid;
    logic                    m_ready;
    logic [SID_W-1:0]        m_winner_stream;
    logic signed [KEY_W-1:0] m_out_ref_id;
    logic signed [KEY_W-1:0] m_out_start;
    logic signed [KEY_W-1:0] m_out_end;
    logic                    m_out_first_mate;
    logic                    m_out_second_mate;
    logic                    m_all_done;

    logic             head_valid [NUM_STREAMS];
    logic             head_done  [NUM_STREAMS];
    akms_rec_t        head_key   [NUM_STREAMS];
    logic [CFG_W-1:0] cfg_streams;

    merge_emit_t emit_q[$];
    merge_emit_t last_emit;
    bit          last_has_emit;
    int          items_sent;
    int          err_count;
    int          idle_cycles;
    int          rx_hold;
    bit          tx_quiet;
    bit          rx_quiet;

    alignment_kway_merge_selector #(
        .NUM_STREAMS(NUM_STREAMS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_stream_id       (s_stream_id),
        .s_stream_ended    (s_stream_ended),
        .s_ref_id          (s_ref_id),
        .s_start_pos       (s_start_pos),
        .s_end_pos         (s_end_pos),
        .s_is_first_mate   (s_is_first_mate),
        .s_is_second_mate  (s_is_second_mate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_winner_stream   (m_winner_stream),
        .m_out_ref_id      (m_out_ref_id),
        .m_out_start       (m_out_start),
        .m_out_end         (m_out_end),
        .m_out_first_mate  (m_out_first_mate),
        .m_out_second_mate (m_out_second_mate),
        .m_all_done        (m_all_done)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int active_streams();
        int n;
        n = int'(cfg_streams);
        if (n == 0) n = 1;
        if (n > NUM_STREAMS) n = NUM_STREAMS;
        return n;
    endfunction

    function automatic bit outranks(akms_rec_t cand, akms_rec_t best);
        logic [3*KEY_W-1:0] kc;
        logic [3*KEY_W-1:0] kb;
        kc = {cand.ref_id ^ SIGN_FLIP, cand.start_pos ^ SIGN_FLIP, cand.end_pos ^ SIGN_FLIP};
        kb = {best.ref_id ^ SIGN_FLIP, best.start_pos ^ SIGN_FLIP, best.end_pos ^ SIGN_FLIP};
        if (kc != kb) return kc < kb;
        if ((cand.mate | best.mate) == MATE_BOTH) return (cand.mate & MATE_SECOND) == 2'b00;
        return 1'b0;
    endfunction

    function automatic bit merge_step(input logic [SID_W-1:0] sid, input logic ended,
                                      input akms_rec_t rec, output merge_emit_t res);
        int n;
        int lead;
        bit found;
        n = active_streams();
        res = '{default: '0};
        found = 1'b0;
        lead = 0;
        if (int'(sid) < n) begin
            if (ended) begin
                head_done[sid] = 1'b1;
            end else begin
                head_key[sid] = rec;
                head_valid[sid] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!head_valid[i] && !head_done[i]) return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (head_valid[i] && (!found || outranks(head_key[i], head_key[lead]))) begin
                lead = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            res.all_done = 1'b1;
            return 1'b1;
        end
        res.winner = lead[SID_W-1:0];
        res.ref_id = head_key[lead].ref_id;
        res.start_pos = head_key[lead].start_pos;
        res.end_pos = head_key[lead].end_pos;
        res.first_mate = head_key[lead].mate[0];
        res.second_mate = head_key[lead].mate[1];
        head_valid[lead] = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    task automatic push_input(input logic [SID_W-1:0] sid, input logic ended,
                              input logic signed [KEY_W-1:0] ref_id,
                              input logic signed [KEY_W-1:0] start_pos,
                              input logic signed [KEY_W-1:0] end_pos,
                              input logic first_mate, input logic second_mate);
        int gap;
        akms_rec_t rec;
        merge_emit_t res;
        bit has_emit;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_stream_id <= sid;
        s_stream_ended <= ended;
        s_ref_id <= ref_id;
        s_start_pos <= start_pos;
        s_end_pos <= end_pos;
        s_is_first_mate <= first_mate;
        s_is_second_mate <= second_mate;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        rec.ref_id = ref_id;
        rec.start_pos = start_pos;
        rec.end_pos = end_pos;
        rec.mate = {second_mate, first_mate};
        has_emit = merge_step(sid, ended, rec, res);
        last_emit = res;
        last_has_emit = has_emit;
        if (has_emit) emit_q.push_back(res);
        items_sent++;
    endtask

    task automatic drain_pause();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (emit_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_stream_count(input logic [CFG_W-1:0] value);
        drain_pause();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_streams = value;
    endtask

    task automatic test_fill_and_order();
        push_input(0, 1'b0, KEY_MAX, KEY_MAX, KEY_MAX, 1'b0, 1'b0);
        push_input(1, 1'b0, KEY_NONE, KEY_NONE, KEY_NONE, 1'b1, 1'b1);
        push_input(2, 1'b0, KEY_NONE, KEY_NONE, KEY_NONE, 1'b1, 1'b0);
        push_input(3, 1'b0, KEY_NONE, KEY_NONE, KEY_NONE, 1'b0, 1'b1);
        for (int s = 4; s < NUM_STREAMS; s++) begin
            push_input(s[SID_W-1:0], 1'b0, 32'sd0, (s - 4) / 3, s % 2, s[0], s[1]);
        end
    endtask

    task automatic test_ties();
        push_input(2, 1'b0, KEY_NONE, KEY_NONE, KEY_NONE, 1'b0, 1'b1);
        push_input(1, 1'b0, KEY_NONE, KEY_NONE, 32'sd0, 1'b0, 1'b0);
        push_input(3, 1'b0, 32'sd0, KEY_MAX, KEY_NONE, 1'b1, 1'b0);
        push_input(1, 1'b1, KEY_MAX, KEY_MAX, KEY_MAX, 1'b1, 1'b1);
    endtask

    task automatic test_register_extremes();
        set_stream_count(5'd0);
        push_input(0, 1'b1, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0);
        push_input(9, 1'b0, 32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b0);
        push_input(0, 1'b1, KEY_NONE, KEY_NONE, KEY_NONE, 1'b1, 1'b1);
        push_input(0, 1'b0, 32'sd7, KEY_NONE, KEY_MAX, 1'b0, 1'b1);
        set_stream_count(5'd31);
        push_input(15, 1'b0, KEY_NONE, 32'sd0, 32'sd0, 1'b1, 1'b1);
        set_stream_count(5'd1);
        push_input(15, 1'b0, 32'sd3, 32'sd3, 32'sd3, 1'b0, 1'b0);
        set_stream_count(5'd16);
    endtask

    task automatic test_backpressure();
        set_stream_count(5'd1);
        tx_quiet = 1'b1;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            push_input(0, 1'b0, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
        tx_quiet = 1'b0;
        drain_pause();
    endtask

    task automatic run_merge_session();
        akms_rec_t lists [NUM_STREAMS][$];
        bit end_sent [NUM_STREAMS];
        akms_rec_t r;
        int n;
        int len;
        int s;
        int pick;
        int off;
        int parked;
        int steps;
        bit stop;
        n = active_streams();
        steps = 0;
        stop = 1'b0;
        for (int i = 0; i < NUM_STREAMS; i++) begin
            end_sent[i] = 1'b0;
            lists[i].delete();
        end
        for (int i = 0; i < n; i++) begin
            len = $urandom_range(0, 4);
            r.ref_id = int'($urandom_range(0, 3)) - 1;
            r.start_pos = int'($urandom_range(0, 20)) - 1;
            r.end_pos = r.start_pos + int'($urandom_range(0, 30));
            for (int k = 0; k < len; k++) begin
                if (k > 0) begin
                    case ($urandom_range(0, 4))
                        1: begin
                            r.end_pos = r.end_pos + int'($urandom_range(1, 8));
                        end
                        2: begin
                            r.start_pos = r.start_pos + int'($urandom_range(1, 8));
                            r.end_pos = r.start_pos + int'($urandom_range(0, 30));
                        end
                        3: begin
                            r.ref_id = r.ref_id + 1;
                            r.start_pos = int'($urandom_range(0, 20)) - 1;
                            r.end_pos = r.start_pos + int'($urandom_range(0, 30));
                        end
                        4: begin
                            if (k == len - 1) begin
                                r.ref_id = KEY_MAX;
                                r.start_pos = KEY_MAX;
                                r.end_pos = KEY_MAX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                r.mate = 2'($urandom_range(0, 3));
                lists[i].push_back(r);
            end
        end
        while (!stop) begin
            pick = -1;
            if (last_has_emit && !last_emit.all_done) begin
                s = int'(last_emit.winner);
                if (s < n && !head_valid[s] && (lists[s].size() > 0 || !end_sent[s])) pick = s;
            end
            if (pick < 0) begin
                off = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++) begin
                    s = (off + i) % n;
                    if (pick < 0 && !head_valid[s] && (lists[s].size() > 0 || !end_sent[s]))
                        pick = s;
                end
            end
            if (pick < 0 && last_has_emit && last_emit.all_done) begin
                stop = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                push_input(SID_W'($urandom_range(0, NUM_STREAMS - 1)),
                           $urandom_range(0, 3) == 0,
                           $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (pick < 0) begin
                parked = 0;
                for (int i = n - 1; i >= 0; i--) begin
                    if (end_sent[i]) parked = i;
                end
                push_input(parked[SID_W-1:0], 1'b1, $urandom, $urandom, $urandom,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (lists[pick].size() > 0) begin
                r = lists[pick].pop_front();
                push_input(pick[SID_W-1:0], 1'b0, r.ref_id, r.start_pos, r.end_pos,
                           r.mate[0], r.mate[1]);
            end else begin
                end_sent[pick] = 1'b1;
                push_input(pick[SID_W-1:0], 1'b1, $urandom, $urandom, $urandom,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            steps++;
            if (steps > SESSION_STEPS) stop = 1'b1;
        end
        push_input(0, 1'b1, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_merges();
        int session;
        int lim;
        int start_count;
        logic [CFG_W-1:0] value;
        session = 0;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            lim = 1 + session / 3;
            if (lim > NUM_STREAMS) lim = NUM_STREAMS;
            value = CFG_W'($urandom_range(1, lim));
            if (lim == NUM_STREAMS && $urandom_range(0, 5) == 0)
                value = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
            set_stream_count(value);
            tx_quiet = (session % 9 == 4);
            rx_quiet = (session % 9 == 4);
            run_merge_session();
            session++;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin : result_sink
        int rx_gap;
        m_ready = 1'b0;
        forever begin
            if (rx_hold > 0) begin
                rx_gap = rx_hold;
                rx_hold = 0;
            end else begin
                rx_gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (rx_gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        merge_emit_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (emit_q.size() == 0) begin
                report_mismatch("result with none pending", m_winner_stream, '0);
            end else begin
                want = emit_q.pop_front();
                if (m_winner_stream !== want.winner)
                    report_mismatch("winner_stream", m_winner_stream, want.winner);
                if (m_out_ref_id !== want.ref_id)
                    report_mismatch("out_ref_id", m_out_ref_id, want.ref_id);
                if (m_out_start !== want.start_pos)
                    report_mismatch("out_start", m_out_start, want.start_pos);
                if (m_out_end !== want.end_pos)
                    report_mismatch("out_end", m_out_end, want.end_pos);
                if (m_out_first_mate !== want.first_mate)
                    report_mismatch("out_first_mate", m_out_first_mate, want.first_mate);
                if (m_out_second_mate !== want.second_mate)
                    report_mismatch("out_second_mate", m_out_second_mate, want.second_mate);
                if (m_all_done !== want.all_done)
                    report_mismatch("all_done", m_all_done, want.all_done);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_stream_id = '0;
        s_stream_ended = 1'b0;
        s_ref_id = '0;
        s_start_pos = '0;
        s_end_pos = '0;
        s_is_first_mate = 1'b0;
        s_is_second_mate = 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_hold = 0;
        items_sent = 0;
        err_count = 0;
        idle_cycles = 0;
        last_has_emit = 1'b0;
        last_emit = '{default: '0};
        cfg_streams = 5'd16;
        for (int i = 0; i < NUM_STREAMS; i++) begin
            head_valid[i] = 1'b0;
            head_done[i] = 1'b0;
            head_key[i] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_fill_and_order();
        test_ties();
        test_register_extremes();
        test_backpressure();
        test_random_merges();
        drain_pause();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/akms_pkg.sv
hw/rtl/akms_ctrl.sv
hw/rtl/akms_dp.sv
hw/rtl/alignment_kway_merge_selector.sv
dv/tb.sv
